// ===== rtl/core/bmhpq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue unit.
// Used by bmhpq_cell and binary_max_heap_priority_queue_unit; no dependencies.
`default_nettype none

package bmhpq_pkg;

   // Default number of keys the queue can hold.
   localparam int CAPACITY_DEFAULT = 64;

   // Field widths of the request and response beats.
   localparam int KEY_W   = 32;
   localparam int FUNC_W  = 2;
   localparam int ENTRY_W = 7;

   // Operation codes carried in req_func.
   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_PEEK    = 2'd2
   } op_type;

   // Status codes returned in rsp_status.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic                    ins_en;
      logic                    ext_en;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/bmhpq_cell.sv =====
// One cell of the sorted key chain: holds a single key slot.
// Depends on bmhpq_pkg for the command struct and key width.
`default_nettype none

module bmhpq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  wire                                 clock,
   input  bmhpq_pkg::cmd_type                  cmd,
   input  wire  [CNT_W-1:0]                    count,
   input  wire  signed [bmhpq_pkg::KEY_W-1:0]  prev_value,
   input  wire                                 prev_keep,
   input  wire  signed [bmhpq_pkg::KEY_W-1:0]  next_value,
   output logic signed [bmhpq_pkg::KEY_W-1:0]  value,
   output logic                                keep
);

   logic signed [bmhpq_pkg::KEY_W-1:0] value_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0] value_in;
   logic                               occupied;

   // The slot holds a live key when its position is below the fill count.
   assign occupied = (count > CNT_W'(INDEX));

   // A live key that is not smaller than the new key stays where it is.
   assign keep  = occupied && (value_ff >= cmd.key);
   assign value = value_ff;

   // Insert opens a gap at the first slot that does not keep its key and
   // shifts the rest one place down; extract shifts everything one place up.
   always_comb begin
      value_in = value_ff;
      if (cmd.ins_en) begin
         if (keep) begin
            value_in = value_ff;
         end else if (prev_keep) begin
            value_in = cmd.key;
         end else begin
            value_in = prev_value;
         end
      end else if (cmd.ext_en) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/binary_max_heap_priority_queue_unit.sv =====
// Priority queue of signed 32-bit keys: insert, extract maximum, peek maximum.
// A response beat is valid in the cycle after its request beat is taken.
// Throughput: one request per cycle while responses are taken at once; the
// chain of cells settles every operation in the cycle that accepts it.
// Reset (synchronous, active high) empties the queue and drops any response.
// Depends on bmhpq_pkg and bmhpq_cell.
`default_nettype none

module binary_max_heap_priority_queue_unit #(
   parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [bmhpq_pkg::FUNC_W-1:0]        req_func,
   input  wire  signed [bmhpq_pkg::KEY_W-1:0]  req_key_in,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [bmhpq_pkg::KEY_W-1:0]  rsp_key_out,
   output logic [1:0]                          rsp_status,
   output logic [bmhpq_pkg::ENTRY_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                               req_take;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic signed [bmhpq_pkg::KEY_W-1:0] rsp_key_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0] rsp_key_in;
   bmhpq_pkg::status_type              rsp_status_ff;
   bmhpq_pkg::status_type              rsp_status_in;
   logic [bmhpq_pkg::ENTRY_W-1:0]      rsp_count_ff;
   bmhpq_pkg::cmd_type                 cmd;
   logic                               is_empty;
   logic                               is_full;

   logic signed [bmhpq_pkg::KEY_W-1:0] cell_value [CAPACITY];
   logic                               cell_keep  [CAPACITY];

   // The output register frees up as soon as its beat is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   // Decode the request beat into a chain command and a response.
   always_comb begin
      cmd.ins_en    = 1'b0;
      cmd.ext_en    = 1'b0;
      cmd.key       = req_key_in;
      count_in      = count_ff;
      rsp_key_in    = '0;
      rsp_status_in = bmhpq_pkg::ST_OK;
      case (req_func)
         bmhpq_pkg::OP_INSERT: begin
            if (is_full) begin
               rsp_status_in = bmhpq_pkg::ST_FULL;
            end else begin
               cmd.ins_en = req_take;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         bmhpq_pkg::OP_EXTRACT: begin
            if (is_empty) begin
               rsp_status_in = bmhpq_pkg::ST_EMPTY;
            end else begin
               cmd.ext_en = req_take;
               rsp_key_in = cell_value[0];
               count_in   = count_ff - CNT_W'(1);
            end
         end
         bmhpq_pkg::OP_PEEK: begin
            if (is_empty) begin
               rsp_status_in = bmhpq_pkg::ST_EMPTY;
            end else begin
               rsp_key_in = cell_value[0];
            end
         end
         default: begin
            rsp_status_in = bmhpq_pkg::ST_OK;
         end
      endcase
   end

   // Chain of cells kept sorted in descending order; cell 0 holds the maximum.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bmhpq_pkg::KEY_W-1:0] prev_value;
      logic                               prev_keep;
      logic signed [bmhpq_pkg::KEY_W-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_value = cell_value[i];
         assign prev_keep  = 1'b1;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_keep  = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      bmhpq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .prev_value (prev_value),
         .prev_keep  (prev_keep),
         .next_value (next_value),
         .value      (cell_value[i]),
         .keep       (cell_keep[i])
      );
   end

   // Response valid flag follows the handshake on both sides.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload is captured with the request beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= bmhpq_pkg::ENTRY_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // A successful extract lowers the count by one and returns the old head.
   a_extract: assert property (@(posedge clock) disable iff (reset)
      (req_take && cmd.ext_en) |=>
         (count_ff == $past(count_ff) - CNT_W'(1)) && (rsp_key_out == $past(cell_value[0])))
      else $error("extract did not pop the head cell");

   // An insert into a full queue is dropped and flagged.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_func == bmhpq_pkg::OP_INSERT) && is_full) |=>
         (rsp_status == bmhpq_pkg::ST_FULL) && $stable(count_ff))
      else $error("insert into full queue not dropped");

   // The head stays the largest live key.
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_W'(1)) |-> (cell_value[0] >= cell_value[1]))
      else $error("head cell is not the maximum");

endmodule

`default_nettype wire

// ===== verif/tb_binary_max_heap_priority_queue_unit.sv =====
// Self-checking testbench for binary_max_heap_priority_queue_unit: random and directed
// insert, extract and peek beats checked against a behavioral heap kept in the bench.
// Depends on bmhpq_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_binary_max_heap_priority_queue_unit;

   localparam int CAPACITY       = bmhpq_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_OPS     = 1400;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 20;

   // Operation code 3 has no meaning in the unit; it must still answer.
   localparam logic [bmhpq_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [bmhpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [bmhpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_type;

   typedef struct {
      logic [bmhpq_pkg::FUNC_W-1:0]       func;
      logic signed [bmhpq_pkg::KEY_W-1:0] key;
      bit                                 hold;   // wait for every answer before sending
   } heap_req_type;

   typedef struct {
      logic signed [bmhpq_pkg::KEY_W-1:0] key;
      bmhpq_pkg::status_type              status;
      logic [bmhpq_pkg::ENTRY_W-1:0]      count;
   } heap_answer_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [bmhpq_pkg::FUNC_W-1:0]       req_func = '0;
   logic signed [bmhpq_pkg::KEY_W-1:0] req_key_in = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [bmhpq_pkg::KEY_W-1:0] rsp_key_out;
   logic [1:0]                         rsp_status;
   logic [bmhpq_pkg::ENTRY_W-1:0]      rsp_entry_count;

   heap_req_type    op_q[$];
   heap_answer_type answer_q[$];

   // Behavioral heap that tracks the unit's contents.
   logic signed [bmhpq_pkg::KEY_W-1:0] model_keys[CAPACITY];
   int                                 model_count = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int gap_left       = 0;
   int burst_left     = 0;
   int ready_run_left = 0;
   int stall_left     = 0;

   binary_max_heap_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_key_in     (req_key_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_out    (rsp_key_out),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the behavioral heap and returns the answer it gives.
   function automatic heap_answer_type heap_apply(
         input logic [bmhpq_pkg::FUNC_W-1:0] func,
         input logic signed [bmhpq_pkg::KEY_W-1:0] key);
      heap_answer_type                    ans;
      int                                 pos;
      int                                 child;
      bit                                 settled;
      logic signed [bmhpq_pkg::KEY_W-1:0] tmp;
      ans.key    = '0;
      ans.status = bmhpq_pkg::ST_OK;
      case (func)
         bmhpq_pkg::OP_INSERT: begin
            if (model_count >= CAPACITY) begin
               ans.status = bmhpq_pkg::ST_FULL;
            end else begin
               pos = model_count;
               model_keys[pos] = key;
               model_count++;
               // Sift up while strictly greater than the parent.
               while (pos > 0 && model_keys[pos] > model_keys[(pos - 1) / 2]) begin
                  tmp = model_keys[pos];
                  model_keys[pos] = model_keys[(pos - 1) / 2];
                  model_keys[(pos - 1) / 2] = tmp;
                  pos = (pos - 1) / 2;
               end
            end
         end
         bmhpq_pkg::OP_EXTRACT: begin
            if (model_count == 0) begin
               ans.status = bmhpq_pkg::ST_EMPTY;
            end else begin
               ans.key = model_keys[0];
               model_count--;
               if (model_count > 0) begin
                  model_keys[0] = model_keys[model_count];
                  // Sift down toward the larger child; the left child wins a tie.
                  pos = 0;
                  settled = 1'b0;
                  while (!settled && 2 * pos + 1 < model_count) begin
                     child = 2 * pos + 1;
                     if (child + 1 < model_count && model_keys[child] < model_keys[child + 1])
                        child++;
                     if (model_keys[pos] >= model_keys[child]) begin
                        settled = 1'b1;
                     end else begin
                        tmp = model_keys[pos];
                        model_keys[pos] = model_keys[child];
                        model_keys[child] = tmp;
                        pos = child;
                     end
                  end
               end
            end
         end
         bmhpq_pkg::OP_PEEK: begin
            if (model_count == 0)
               ans.status = bmhpq_pkg::ST_EMPTY;
            else
               ans.key = model_keys[0];
         end
         default: begin
         end
      endcase
      ans.count = bmhpq_pkg::ENTRY_W'(model_count);
      return ans;
   endfunction

   function automatic void queue_op(input logic [bmhpq_pkg::FUNC_W-1:0] func,
                                    input logic signed [bmhpq_pkg::KEY_W-1:0] key,
                                    input bit hold);
      heap_req_type item;
      item.func = func;
      item.key  = key;
      item.hold = hold;
      op_q.insert(op_q.size(), item);
   endfunction

   // Keys lean toward a narrow band so that ties and duplicates are common.
   function automatic logic signed [bmhpq_pkg::KEY_W-1:0] pick_key();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return -1;
         endcase
      end else if (r <= 3) begin
         v = $urandom_range(0, 16);
         return v - 8;
      end
      return $urandom;
   endfunction

   function automatic logic [bmhpq_pkg::FUNC_W-1:0] pick_func(input mix_type mix);
      int r;
      int ins_pct;
      int ext_pct;
      case (mix)
         MIX_FILL:  begin ins_pct = 80; ext_pct = 10; end
         MIX_DRAIN: begin ins_pct = 12; ext_pct = 75; end
         default:   begin ins_pct = 45; ext_pct = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct)
         return bmhpq_pkg::OP_INSERT;
      if (r < ins_pct + ext_pct)
         return bmhpq_pkg::OP_EXTRACT;
      if (r < 97)
         return bmhpq_pkg::OP_PEEK;
      return OP_UNUSED;
   endfunction

   // Request driver: sends beats in bursts with random gaps, predicting each accepted one.
   always @(posedge clock) begin
      heap_req_type nxt;
      int           r;
      logic         took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took)
            answer_q.insert(answer_q.size(), heap_apply(req_func, req_key_in));
         if (!req_valid || took) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (op_q.size() == 0 || (op_q[0].hold && answer_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               nxt = op_q.pop_front();
               req_valid  <= 1'b1;
               req_func   <= nxt.func;
               req_key_in <= nxt.key;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  r = $urandom_range(0, 9);
                  gap_left = (r < 3) ? 0
                           : (r < 9) ? $urandom_range(1, 4) : $urandom_range(8, 20);
               end
            end
         end
      end
   end

   // Response monitor: checks every accepted beat and stalls on its own pattern.
   always @(posedge clock) begin
      heap_answer_type exp_ans;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response beat with no answer pending: key %0d status %0d count %0d",
                        $time, rsp_key_out, rsp_status, rsp_entry_count);
               mismatch_count++;
            end else begin
               exp_ans = answer_q.pop_front();
               if (rsp_key_out !== exp_ans.key) begin
                  $display("%0t: key_out expected %0d actual %0d",
                           $time, exp_ans.key, rsp_key_out);
                  mismatch_count++;
               end
               if (rsp_status !== exp_ans.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_ans.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_entry_count !== exp_ans.count) begin
                  $display("%0t: entry_count expected %0d actual %0d",
                           $time, exp_ans.count, rsp_entry_count);
                  mismatch_count++;
               end
            end
         end
         // Runs of ready, then stalls; now and then a long stall.
         if (ready_run_left > 0) begin
            ready_run_left--;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            ready_run_left = $urandom_range(0, 30);
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                     : $urandom_range(0, 3);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_max_heap_priority_queue_unit regression: fail");
         $finish;
      end
   end

   initial begin
      int      seg;
      int      seg_len;
      int      total;
      mix_type mix;

      // Directed: empty cases, extremes, duplicates, unused code, drain to empty.
      queue_op(bmhpq_pkg::OP_PEEK, '0, 1'b0);
      queue_op(bmhpq_pkg::OP_EXTRACT, '0, 1'b0);
      queue_op(OP_UNUSED, KEY_MAX, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, KEY_MIN, 1'b0);
      queue_op(bmhpq_pkg::OP_PEEK, '0, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, KEY_MAX, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, '0, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, -1, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, KEY_MAX, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, 5, 1'b0);
      queue_op(bmhpq_pkg::OP_INSERT, 5, 1'b0);
      queue_op(bmhpq_pkg::OP_PEEK, -1, 1'b0);
      queue_op(OP_UNUSED, KEY_MIN, 1'b0);
      for (int i = 0; i < 7; i++)
         queue_op(bmhpq_pkg::OP_EXTRACT, KEY_MAX, 1'b0);
      queue_op(bmhpq_pkg::OP_EXTRACT, '0, 1'b0);
      queue_op(bmhpq_pkg::OP_PEEK, '0, 1'b0);

      // Random: a fill-heavy and a drain-heavy segment first, then mixed segments.
      total = 0;
      seg = 0;
      while (total < RANDOM_OPS) begin
         if (seg == 0)
            mix = MIX_FILL;
         else if (seg == 1)
            mix = MIX_DRAIN;
         else
            mix = mix_type'($urandom_range(0, 2));
         seg_len = (seg < 2) ? 100 : $urandom_range(20, 120);
         for (int i = 0; i < seg_len; i++)
            queue_op(pick_func(mix), pick_key(), (i == 0) && (seg % 4 == 0));
         total += seg_len;
         seg++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (op_q.size() != 0 || req_valid || answer_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("binary_max_heap_priority_queue_unit regression: pass");
      else
         $display("binary_max_heap_priority_queue_unit regression: fail");
      $finish;
   end

endmodule
